### design/wsfd_pkg.sv
package wsfd_pkg;

	// default depth of the frame store
	localparam int unsigned MAX_FRAME_BYTES = 17;

	// byte that opens a frame
	localparam logic [7:0] SYNC_BYTE = 8'hff;

	// known frame types
	localparam logic [7:0] TYPE_41 = 8'h41;
	localparam logic [7:0] TYPE_42 = 8'h42;
	localparam logic [7:0] TYPE_44 = 8'h44;
	localparam logic [7:0] TYPE_46 = 8'h46;
	localparam logic [7:0] TYPE_47 = 8'h47;
	localparam logic [7:0] TYPE_48 = 8'h48;
	localparam logic [7:0] TYPE_60 = 8'h60;

	// end-of-frame status codes
	typedef enum logic [1:0] {
		FS_GOOD     = 2'd0,
		FS_BAD_SUM  = 2'd1,
		FS_BAD_TYPE = 2'd2
	} frame_status_t;

	// parser and emitter states
	typedef enum logic [2:0] {
		ST_HUNT,
		ST_SKIP,
		ST_TYPE,
		ST_BODY,
		ST_READ,
		ST_SEND,
		ST_STATUS
	} state_t;

	// total frame length per type, zero for an unknown type
	function automatic logic [4:0] frame_length(input logic [7:0] t);
		logic [4:0] len;
		len = 5'd0;
		case (t)
			TYPE_41: len = 5'd17;
			TYPE_42: len = 5'd12;
			TYPE_44: len = 5'd7;
			TYPE_46: len = 5'd8;
			TYPE_47: len = 5'd5;
			TYPE_48: len = 5'd11;
			TYPE_60: len = 5'd12;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

### design/weather_sensor_frame_deframer_core.sv
// Sensor link deframer. Raw stream bytes arrive on the slave side, one per
// transfer; the block hunts for a 0xff sync byte, takes the header and type
// bytes, collects the frame into an internal memory and checks its 16-bit
// little-endian checksum. A byte is taken only while the output register is
// free. Once the last byte of a good frame of total length L is in, the
// input is held off while the L-2 stored bytes are replayed from the memory,
// each with one memory read and then one load of the output register,
// followed by a status item; each load waits while the master side stalls.
// A bad checksum or an unknown type gives only the status item. The master
// side carries frame_type, byte_index, byte_value and frame_status in
// m_tdata, is_status in m_tuser and last_of_run in m_tlast; a status item
// always has m_tlast set.
module weather_sensor_frame_deframer_core #(
	parameter int unsigned MAX_FRAME_BYTES = wsfd_pkg::MAX_FRAME_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] stream_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] frame_type, [11:8] byte_index,
	                               // [19:12] byte_value, [21:20] frame_status, zero above
	output logic        m_tuser,   // [0] is_status
	output logic        m_tlast    // last_of_run
);

	localparam int unsigned AW = $clog2(MAX_FRAME_BYTES);

	wsfd_pkg::state_t state_q, state_d;

	logic [7:0]  header_q;
	logic [7:0]  type_q;
	logic [4:0]  len_q;
	logic [4:0]  cnt_q;
	logic [15:0] sum_q;
	logic [7:0]  chk_lo_q;
	logic [4:0]  rd_idx_q;

	// frame store
	logic [7:0]  mem [MAX_FRAME_BYTES];
	logic [7:0]  rdata_q;
	logic        mem_we;
	logic [4:0]  mem_waddr;

	// output register
	logic        m_valid_q;
	logic        out_status_q;
	logic [7:0]  out_type_q;
	logic [3:0]  out_idx_q;
	logic [7:0]  out_val_q;
	logic [1:0]  out_fstat_q;
	logic        out_last_q;

	logic        out_free;
	logic        in_xfer;
	logic        out_load;
	logic        out_is_status;
	logic [7:0]  out_type_d;
	logic [3:0]  out_idx_d;
	logic [7:0]  out_val_d;
	logic [1:0]  out_fstat_d;

	logic [7:0]  b;
	logic [4:0]  type_len;
	logic [4:0]  cnt_inc;
	logic        frame_done;
	logic        sum_ok;
	logic [4:0]  data_items;

	assign b          = s_tdata;
	assign out_free   = !m_valid_q || m_tready;
	assign in_xfer    = s_tvalid && s_tready;
	assign type_len   = wsfd_pkg::frame_length(b);
	assign cnt_inc    = cnt_q + 5'd1;
	assign frame_done = (cnt_inc == len_q);
	assign sum_ok     = ({b, chk_lo_q} == sum_q);
	assign data_items = len_q - 5'd2;

	// next state, handshake and output load
	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = cnt_q;
		out_load      = 1'b0;
		out_is_status = 1'b1;
		out_type_d    = type_q;
		out_idx_d     = 4'd0;
		out_val_d     = 8'd0;
		out_fstat_d   = wsfd_pkg::FS_GOOD;
		unique case (state_q)
			wsfd_pkg::ST_HUNT: begin
				s_tready = out_free;
				if (in_xfer && b == wsfd_pkg::SYNC_BYTE) begin
					state_d = wsfd_pkg::ST_SKIP;
				end
			end
			wsfd_pkg::ST_SKIP: begin
				s_tready  = out_free;
				mem_waddr = 5'd0;
				if (in_xfer && b != wsfd_pkg::SYNC_BYTE) begin
					mem_we  = 1'b1;
					state_d = wsfd_pkg::ST_TYPE;
				end
			end
			wsfd_pkg::ST_TYPE: begin
				s_tready  = out_free;
				mem_waddr = 5'd1;
				if (in_xfer) begin
					if (type_len == 5'd0) begin
						out_load    = 1'b1;
						out_type_d  = b;
						out_fstat_d = wsfd_pkg::FS_BAD_TYPE;
						state_d     = wsfd_pkg::ST_HUNT;
					end else begin
						mem_we  = 1'b1;
						state_d = wsfd_pkg::ST_BODY;
					end
				end
			end
			wsfd_pkg::ST_BODY: begin
				s_tready = out_free;
				if (in_xfer) begin
					mem_we = ({1'b0, cnt_q} < 6'(MAX_FRAME_BYTES));
					if (frame_done) begin
						if (sum_ok) begin
							state_d = wsfd_pkg::ST_READ;
						end else begin
							out_load    = 1'b1;
							out_fstat_d = wsfd_pkg::FS_BAD_SUM;
							state_d     = wsfd_pkg::ST_HUNT;
						end
					end
				end
			end
			wsfd_pkg::ST_READ: begin
				state_d = wsfd_pkg::ST_SEND;
			end
			wsfd_pkg::ST_SEND: begin
				if (out_free) begin
					out_load      = 1'b1;
					out_is_status = 1'b0;
					out_idx_d     = rd_idx_q[3:0];
					out_val_d     = rdata_q;
					if (rd_idx_q + 5'd1 == data_items) begin
						state_d = wsfd_pkg::ST_STATUS;
					end else begin
						state_d = wsfd_pkg::ST_READ;
					end
				end
			end
			wsfd_pkg::ST_STATUS: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = wsfd_pkg::ST_HUNT;
				end
			end
			default: begin
				state_d = wsfd_pkg::ST_HUNT;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsfd_pkg::ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	// parse registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= 8'd0;
			type_q   <= 8'd0;
			len_q    <= 5'd0;
			cnt_q    <= 5'd0;
			sum_q    <= 16'd0;
			chk_lo_q <= 8'd0;
			rd_idx_q <= 5'd0;
		end else begin
			if (in_xfer) begin
				case (state_q)
					wsfd_pkg::ST_SKIP: begin
						if (b != wsfd_pkg::SYNC_BYTE) begin
							header_q <= b;
						end
					end
					wsfd_pkg::ST_TYPE: begin
						type_q <= b;
						if (type_len != 5'd0) begin
							len_q <= type_len;
							cnt_q <= 5'd2;
							sum_q <= {8'h00, header_q} + {8'h00, b};
						end
					end
					wsfd_pkg::ST_BODY: begin
						if (cnt_q + 5'd2 < len_q) begin
							sum_q <= sum_q + {8'h00, b};
						end
						if (cnt_q + 5'd2 == len_q) begin
							chk_lo_q <= b;
						end
						cnt_q <= cnt_inc;
					end
					default: begin
					end
				endcase
			end
			// replay pointer
			if (state_q == wsfd_pkg::ST_BODY && in_xfer && frame_done) begin
				rd_idx_q <= 5'd0;
			end else if (state_q == wsfd_pkg::ST_SEND && out_free) begin
				rd_idx_q <= rd_idx_q + 5'd1;
			end
		end
	end

	// frame store, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr[AW-1:0]] <= b;
		end
		rdata_q <= mem[rd_idx_q[AW-1:0]];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_is_status;
			out_type_q   <= out_type_d;
			out_idx_q    <= out_idx_d;
			out_val_q    <= out_val_d;
			out_fstat_q  <= out_fstat_d;
			out_last_q   <= out_is_status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, out_fstat_q, out_val_q, out_idx_q, out_type_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	// input is held off during replay
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wsfd_pkg::ST_READ || state_q == wsfd_pkg::ST_SEND ||
		 state_q == wsfd_pkg::ST_STATUS) |-> !s_tready)
		else $error("input accepted during frame replay");

	// collection never runs past the frame length
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wsfd_pkg::ST_BODY |-> (cnt_q < len_q))
		else $error("byte count beyond frame length");

	// output register is never overwritten while full and stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten");

	// status items close a run, data items never do
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == m_tlast))
		else $error("status and last flags disagree");

	// replay reads stay within the data bytes of the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wsfd_pkg::ST_SEND |-> (rd_idx_q < data_items))
		else $error("replay pointer out of range");

endmodule

### tb/sv/weather_sensor_frame_deframer_core_tb.sv
`timescale 1ns / 1ps

module weather_sensor_frame_deframer_core_tb;
	import wsfd_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned TAIL_CYCLES  = 80;
	localparam int unsigned ITEMS_PER_STEP = 115;

	localparam logic [7:0] KNOWN_TYPES [7] = '{TYPE_41, TYPE_42, TYPE_44, TYPE_46,
		TYPE_47, TYPE_48, TYPE_60};

	// one result item as it leaves the master side
	typedef struct packed {
		logic       is_status;
		logic [7:0] frame_type;
		logic [3:0] byte_index;
		logic [7:0] byte_value;
		logic [1:0] frame_status;
		logic       last_of_run;
	} frame_result_t;

	// parser position of the predictor
	typedef enum logic [1:0] {
		P_HUNT,
		P_SKIP,
		P_TYPE,
		P_BODY
	} parse_pos_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	logic [7:0]    stream_bytes [$];
	frame_result_t expected_results [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_left = 0;
	logic        hold_go = 1'b0;

	int unsigned cycle_count = 0;
	int unsigned bytes_offered = 0;
	int unsigned errors = 0;
	int unsigned results_checked = 0;
	int unsigned frames_good = 0;
	int unsigned frames_bad_sum = 0;
	int unsigned frames_bad_type = 0;

	// predictor state
	parse_pos_t  pp_pos;
	logic [7:0]  pp_header;
	logic [7:0]  pp_type;
	logic [4:0]  pp_length;
	logic [4:0]  pp_count;
	logic [15:0] pp_sum;
	logic [7:0]  pp_store [MAX_FRAME_BYTES];

	weather_sensor_frame_deframer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// total frame length by type byte, zero when the type is not known
	function automatic logic [4:0] type_len(input logic [7:0] t);
		case (t)
			TYPE_41: return 5'd17;
			TYPE_42, TYPE_60: return 5'd12;
			TYPE_44: return 5'd7;
			TYPE_46: return 5'd8;
			TYPE_47: return 5'd5;
			TYPE_48: return 5'd11;
			default: return 5'd0;
		endcase
	endfunction

	function automatic frame_result_t status_item(input logic [7:0] t,
		input frame_status_t fs);
		frame_result_t r;
		r = '0;
		r.is_status    = 1'b1;
		r.frame_type   = t;
		r.frame_status = fs;
		r.last_of_run  = 1'b1;
		return r;
	endfunction

	// advance the predictor by one accepted stream byte
	task automatic deframe_byte(input logic [7:0] b);
		frame_result_t r;
		logic [15:0]   chk;
		case (pp_pos)
			P_HUNT: begin
				if (b == SYNC_BYTE)
					pp_pos = P_SKIP;
			end
			P_SKIP: begin
				if (b != SYNC_BYTE) begin
					pp_header = b;
					pp_pos = P_TYPE;
				end
			end
			P_TYPE: begin
				pp_type = b;
				pp_length = type_len(b);
				if (pp_length == 5'd0) begin
					expected_results.push_back(status_item(b, FS_BAD_TYPE));
					frames_bad_type++;
					pp_pos = P_HUNT;
				end else begin
					pp_store[0] = pp_header;
					pp_store[1] = pp_type;
					pp_count = 5'd2;
					pp_sum = {8'h00, pp_header} + {8'h00, pp_type};
					pp_pos = P_BODY;
				end
			end
			default: begin
				if (pp_count < MAX_FRAME_BYTES)
					pp_store[pp_count] = b;
				if (pp_count + 5'd2 < pp_length)
					pp_sum = pp_sum + {8'h00, b};
				pp_count = pp_count + 5'd1;
				if (pp_count >= pp_length) begin
					pp_pos = P_HUNT;
					chk = {pp_store[pp_length - 1], pp_store[pp_length - 2]};
					if (chk != pp_sum) begin
						expected_results.push_back(status_item(pp_type, FS_BAD_SUM));
						frames_bad_sum++;
					end else begin
						// replay header, type and payload, then the status
						for (int i = 0; i + 2 < pp_length; i++) begin
							r = '0;
							r.frame_type = pp_type;
							r.byte_index = i[3:0];
							r.byte_value = pp_store[i];
							expected_results.push_back(r);
						end
						expected_results.push_back(status_item(pp_type, FS_GOOD));
						frames_good++;
					end
				end
			end
		endcase
	endtask

	function automatic bit field_matches(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got)
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		return want === got;
	endfunction

	// predictor and result checker
	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		bit            ok;
		if (!arst_n) begin
			pp_pos    = P_HUNT;
			pp_header = 8'h00;
			pp_type   = 8'h00;
			pp_length = 5'd0;
			pp_count  = 5'd0;
			pp_sum    = 16'h0000;
		end else begin
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result expected none actual %h/%b/%b",
						$time, m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					want = expected_results.pop_front();
					ok = 1'b1;
					ok &= field_matches("is_status", 8'(want.is_status), 8'(m_tuser));
					ok &= field_matches("frame_type", want.frame_type, m_tdata[7:0]);
					ok &= field_matches("byte_index", 8'(want.byte_index),
						8'(m_tdata[11:8]));
					ok &= field_matches("byte_value", want.byte_value, m_tdata[19:12]);
					ok &= field_matches("frame_status", 8'(want.frame_status),
						8'(m_tdata[21:20]));
					ok &= field_matches("last_of_run", 8'(want.last_of_run), 8'(m_tlast));
					ok &= field_matches("tdata pad", 8'h00, 8'(m_tdata[23:22]));
					if (!ok)
						errors++;
					results_checked++;
				end
			end
		end
	end

	// stream byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
		end else if (!s_tvalid || s_tready) begin
			if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tdata  <= stream_bytes.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_go)
			hold_left <= LONG_HOLD;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// result receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic offer(input logic [7:0] b);
		stream_bytes.push_back(b);
		bytes_offered++;
	endtask

	// sync, header, type, body and little-endian checksum, optionally spoilt
	task automatic send_frame(input logic [7:0] hdr, input logic [7:0] t,
		input logic [7:0] body [$], input bit corrupt);
		logic [15:0] sum;
		sum = {8'h00, hdr} + {8'h00, t};
		offer(SYNC_BYTE);
		offer(hdr);
		offer(t);
		foreach (body[i]) begin
			offer(body[i]);
			sum = sum + {8'h00, body[i]};
		end
		if (corrupt)
			sum = sum ^ (16'h0001 << $urandom_range(15));
		offer(sum[7:0]);
		offer(sum[15:8]);
	endtask

	// random frames, mostly well formed, with broken ones and line noise
	task automatic random_frames(input int unsigned target);
		int unsigned start;
		int unsigned pick;
		int unsigned n;
		logic [7:0]  t;
		logic [7:0]  body [$];
		start = bytes_offered;
		while (bytes_offered - start < target) begin
			pick = $urandom_range(99);
			body.delete();
			t = KNOWN_TYPES[$urandom_range(6)];
			n = type_len(t) - 4;
			for (int i = 0; i < n; i++)
				body.push_back(8'($urandom_range(255)));
			if (pick < 88 && $urandom_range(3) == 0)
				offer(SYNC_BYTE);
			if (pick < 68) begin
				send_frame(8'($urandom_range(254)), t, body, 1'b0);
			end else if (pick < 80) begin
				send_frame(8'($urandom_range(254)), t, body, 1'b1);
			end else if (pick < 88) begin
				do
					t = 8'($urandom_range(255));
				while (type_len(t) != 0);
				offer(SYNC_BYTE);
				offer(8'($urandom_range(254)));
				offer(t);
			end else if (pick < 94) begin
				// frame cut short, the next bytes run on into it
				offer(SYNC_BYTE);
				offer(8'($urandom_range(254)));
				offer(t);
				n = $urandom_range(n);
				for (int i = 0; i < n; i++)
					offer(body[i]);
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					offer(8'($urandom_range(255)));
			end
		end
	endtask

	// let everything queued be sent and every result arrive
	task automatic drain;
		while (stream_bytes.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [7:0]  body [$];
		int unsigned send_pcts [4];
		int unsigned recv_pcts [4];
		send_pcts = '{0, 79, 0, 20};
		recv_pcts = '{0, 0, 79, 20};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: ignored byte, repeated syncs, 0xff as unknown type
		offer(8'h00);
		offer(SYNC_BYTE);
		offer(SYNC_BYTE);
		offer(8'h00);
		offer(SYNC_BYTE);
		// shortest good frame, then another of that type with a wrong checksum
		body.delete();
		body.push_back(8'h10);
		send_frame(8'hfe, TYPE_47, body, 1'b0);
		offer(SYNC_BYTE);
		offer(8'h00);
		offer(TYPE_47);
		offer(8'h00);
		offer(8'h47);
		offer(8'h01);
		// sync byte inside a frame body
		body.delete();
		body.push_back(8'hff);
		body.push_back(8'h00);
		body.push_back(8'h80);
		send_frame(8'h01, TYPE_44, body, 1'b0);
		// sender waits for every result before going on
		drain();

		for (int k = 0; k < 4; k++) begin
			send_idle_pct  = send_pcts[k];
			recv_stall_pct = recv_pcts[k];
			random_frames(ITEMS_PER_STEP);
			if (k == 0) begin
				// receiver holds off while the sender keeps offering
				hold_go <= 1'b1;
				@(negedge clk);
				hold_go <= 1'b0;
			end
			drain();
		end

		$display("%0d stream bytes offered, %0d results checked", bytes_offered,
			results_checked);
		$display("frames: %0d good, %0d bad checksum, %0d unknown type", frames_good,
			frames_bad_sum, frames_bad_type);
		if (errors == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
